// ===== rtl/mcr_pkg.sv =====
// Package: shared types, codes and constants of the midpoint circle rasteriser.
`timescale 1ns / 1ps
package mcr_pkg;

  // Fixed field widths of the channel words
  localparam int unsigned CENTER_W    = 10;
  localparam int unsigned RADIUS_W    = 10;
  localparam int unsigned POINT_W     = 12;
  localparam int unsigned RADIUS_BITS = 10;

  // Decision value increments
  localparam int unsigned DEC_INIT = 1;
  localparam int unsigned DEC_EAST = 3;
  localparam int unsigned DEC_DIAG = 5;

  // Octant walk emits eight mirrored points per drawing word
  localparam int unsigned NUM_POINTS = 8;
  localparam int unsigned POINT_IDX_W = $clog2(NUM_POINTS);

  // Depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [0:0] {
    FUNC_START = 1'b0,
    FUNC_STEP  = 1'b1
  } func_t;

  // One octant position handed from the front to the back
  typedef struct packed {
    logic [CENTER_W-1:0] cx;
    logic [CENTER_W-1:0] cy;
    logic [POINT_W-1:0]  ox;
    logic [POINT_W-1:0]  oy;
    logic                fin;
  } job_t;

  // Mirror control for one of the eight points
  typedef struct packed {
    logic swap;
    logic neg_x;
    logic neg_y;
  } mirror_t;

  // Order: (x,y) (y,x) (-y,-x) (x,-y) (-x,-y) (-y,x) (y,-x) (-x,y)
  function automatic mirror_t point_mirror(input logic [POINT_IDX_W-1:0] idx);
    mirror_t m;
    begin
      m = '0;
      unique case (idx)
        3'd0: m = '{swap: 1'b0, neg_x: 1'b0, neg_y: 1'b0};
        3'd1: m = '{swap: 1'b1, neg_x: 1'b0, neg_y: 1'b0};
        3'd2: m = '{swap: 1'b1, neg_x: 1'b1, neg_y: 1'b1};
        3'd3: m = '{swap: 1'b0, neg_x: 1'b0, neg_y: 1'b1};
        3'd4: m = '{swap: 1'b0, neg_x: 1'b1, neg_y: 1'b1};
        3'd5: m = '{swap: 1'b1, neg_x: 1'b1, neg_y: 1'b0};
        3'd6: m = '{swap: 1'b1, neg_x: 1'b0, neg_y: 1'b1};
        3'd7: m = '{swap: 1'b0, neg_x: 1'b1, neg_y: 1'b0};
        default: m = '0;
      endcase
      return m;
    end
  endfunction

endpackage

// ===== rtl/mcr_if.sv =====
// Interfaces: request channel and pixel channel of the circle rasteriser.
`timescale 1ns / 1ps
interface mcr_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 func;
  logic [mcr_pkg::CENTER_W-1:0]         center_x;
  logic [mcr_pkg::CENTER_W-1:0]         center_y;
  logic [mcr_pkg::RADIUS_W-1:0]         radius;

  modport source (output valid, func, center_x, center_y, radius, input ready);
  modport sink   (input valid, func, center_x, center_y, radius, output ready);
endinterface

interface mcr_pix_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mcr_pkg::POINT_W-1:0]   point_x;
  logic signed [mcr_pkg::POINT_W-1:0]   point_y;
  logic                                 last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

// ===== rtl/mcr_front.sv =====
// Front: accepts request words, walks the octant state and queues positions.
`timescale 1ns / 1ps
module mcr_front #(
  parameter int unsigned RADIUS_BITS = mcr_pkg::RADIUS_BITS
) (
  input  logic            clk,
  input  logic            rst,
  mcr_req_if.sink         req,
  input  logic            full,
  output logic            push,
  output mcr_pkg::job_t   push_data
);

  localparam int unsigned DW = RADIUS_BITS + 2;
  localparam int unsigned PW = mcr_pkg::POINT_W;

  logic [RADIUS_BITS-1:0]        offset_x, offset_x_next;
  logic [RADIUS_BITS-1:0]        offset_y, offset_y_next;
  logic [DW-1:0]                 decision, decision_next;
  logic [mcr_pkg::CENTER_W-1:0]  hold_center_x, hold_center_y;
  logic                          active;

  logic                          take;
  logic                          is_start;
  logic                          fin;
  logic [RADIUS_BITS-1:0]        radius_r;
  logic [RADIUS_BITS+mcr_pkg::RADIUS_W-1:0] radius_ext;
  logic [RADIUS_BITS+PW-1:0]     x_ext, y_ext;
  logic [DW-1:0]                 two_x, two_y, r_ext;

  assign req.ready = !full;
  assign take      = req.valid && req.ready;
  assign is_start  = (req.func == mcr_pkg::FUNC_START);
  assign push      = take && (is_start || active);

  assign radius_ext = {{RADIUS_BITS{1'b0}}, req.radius};
  assign radius_r   = radius_ext[RADIUS_BITS-1:0];
  assign two_x      = {1'b0, offset_x, 1'b0};
  assign two_y      = {1'b0, offset_y, 1'b0};
  assign r_ext      = {2'b00, radius_r};

  always_comb begin
    if (is_start) begin
      offset_x_next = '0;
      offset_y_next = radius_r;
      decision_next = DW'(mcr_pkg::DEC_INIT) - r_ext;
    end else if (decision[DW-1]) begin
      offset_x_next = offset_x + RADIUS_BITS'(1);
      offset_y_next = offset_y;
      decision_next = decision + two_x + DW'(mcr_pkg::DEC_EAST);
    end else begin
      offset_x_next = offset_x + RADIUS_BITS'(1);
      offset_y_next = offset_y - RADIUS_BITS'(1);
      decision_next = decision + two_x - two_y + DW'(mcr_pkg::DEC_DIAG);
    end
  end

  assign fin   = (offset_y_next <= offset_x_next);
  assign x_ext = {{PW{1'b0}}, offset_x_next};
  assign y_ext = {{PW{1'b0}}, offset_y_next};

  always_comb begin
    push_data.cx  = is_start ? req.center_x : hold_center_x;
    push_data.cy  = is_start ? req.center_y : hold_center_y;
    push_data.ox  = x_ext[PW-1:0];
    push_data.oy  = y_ext[PW-1:0];
    push_data.fin = fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x      <= '0;
      offset_y      <= '0;
      decision      <= '0;
      hold_center_x <= '0;
      hold_center_y <= '0;
      active        <= 1'b0;
    end else if (push) begin
      offset_x      <= offset_x_next;
      offset_y      <= offset_y_next;
      decision      <= decision_next;
      hold_center_x <= push_data.cx;
      hold_center_y <= push_data.cy;
      active        <= !fin;
    end
  end

endmodule

// ===== rtl/mcr_queue.sv =====
// Queue: short register queue of octant positions between front and back.
`timescale 1ns / 1ps
module mcr_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mcr_pkg::job_t   push_data,
  input  logic            pop,
  output mcr_pkg::job_t   head,
  output logic            not_empty,
  output logic            full
);

  localparam int unsigned DEPTH = mcr_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  mcr_pkg::job_t     entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;

  assign head      = entries[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/mcr_back.sv =====
// Back: expands each queued position into eight mirrored pixels, one a cycle while pix is not stalled.
`timescale 1ns / 1ps
module mcr_back (
  input  logic            clk,
  input  logic            rst,
  input  mcr_pkg::job_t   head,
  input  logic            not_empty,
  output logic            pop,
  mcr_pix_if.source       pix
);

  localparam int unsigned PW = mcr_pkg::POINT_W;
  localparam int unsigned IW = mcr_pkg::POINT_IDX_W;

  logic [IW-1:0]    idx;
  logic             advance;
  logic             emit;
  mcr_pkg::mirror_t mir;
  logic [PW-1:0]    cx12, cy12, ax, ay, px, py;

  assign advance = !pix.valid || pix.ready;
  assign emit    = advance && not_empty;
  assign pop     = emit && (idx == IW'(mcr_pkg::NUM_POINTS - 1));

  assign mir  = mcr_pkg::point_mirror(idx);
  assign cx12 = {{(PW - mcr_pkg::CENTER_W){1'b0}}, head.cx};
  assign cy12 = {{(PW - mcr_pkg::CENTER_W){1'b0}}, head.cy};
  assign ax   = mir.swap ? head.oy : head.ox;
  assign ay   = mir.swap ? head.ox : head.oy;
  assign px   = mir.neg_x ? cx12 - ax : cx12 + ax;
  assign py   = mir.neg_y ? cy12 - ay : cy12 + ay;

  always_ff @(posedge clk) begin
    if (rst) begin
      pix.valid <= 1'b0;
      idx       <= '0;
    end else if (advance) begin
      pix.valid <= not_empty;
      if (emit) begin
        idx <= idx + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pix.point_x    <= px;
      pix.point_y    <= py;
      pix.last_point <= head.fin && (idx == IW'(mcr_pkg::NUM_POINTS - 1));
    end
  end

endmodule

// ===== rtl/midpoint_circle_rasterizer.sv =====
// Top level: midpoint circle rasteriser with eight-way symmetric pixel output.
`timescale 1ns / 1ps
// Usage
//   req : request words. func START loads centre and radius and draws the first
//         octant position; func STEP advances the walk by one column. A STEP
//         while no circle is running is taken and dropped.
//   pix : pixel words, eight per drawing request, in the fixed mirror order;
//         last_point marks the eighth pixel of the final position of a circle.
// Timing
//   When the block is empty, the first pixel of a request is registered in the
//   queue entry and then in the pixel output register before it appears on pix.
//   The back end issues one pixel per cycle through its output register while
//   pix.ready allows, and pops a position only after its eighth pixel, so a
//   drawing request occupies it until all eight pixels are issued. The front
//   takes a request whenever the two-entry queue has room. The queue holds
//   the request being drawn, so one more may wait behind it.
// Reset
//   Synchronous, active high: empties the queue, drops the output word and
//   leaves the walk idle with all offsets and the centre at zero.
// Stall
//   When pix.ready is low the pixel word holds; the queue fills and then
//   req.ready drops until the back end moves on.
module midpoint_circle_rasterizer #(
  parameter int unsigned RADIUS_BITS = mcr_pkg::RADIUS_BITS
) (
  input  logic      clk,
  input  logic      rst,
  mcr_req_if.sink   req,
  mcr_pix_if.source pix
);

  logic          push;
  logic          pop;
  logic          full;
  logic          not_empty;
  mcr_pkg::job_t push_data;
  mcr_pkg::job_t head;

  // Accept requests and advance the octant walk
  mcr_front #(
    .RADIUS_BITS (RADIUS_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  // Hold positions until the back end has drawn them
  mcr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .full      (full)
  );

  // Mirror each position into eight pixels
  mcr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .not_empty (not_empty),
    .pop       (pop),
    .pix       (pix)
  );

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("queue read while empty");

  a_start_queued: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && (req.func == mcr_pkg::FUNC_START)) |-> push)
    else $error("start request not queued");

  // A last pixel is either freshly loaded at a pop or held under a stall
  a_last_on_pop: assert property (@(posedge clk) disable iff (rst)
    (pix.valid && pix.last_point) |-> ($past(pop) || $past(pix.valid && !pix.ready)))
    else $error("last pixel not at end of a position");
`endif

endmodule
